### design/mbet_pkg.sv
// Shared constants and control/status types for the escape-time core.
package mbet_pkg;

	localparam int FRAC_BITS = 28;
	localparam int IN_W      = 31;
	// z needs 3 integer bits plus sign, and must also hold any input point
	localparam int Z_W       = (FRAC_BITS + 4 > IN_W + 1) ? FRAC_BITS + 4 : IN_W + 1;
	localparam int P_W       = 2 * Z_W;
	localparam int CNT_W     = 8;

	localparam logic [CNT_W-1:0] MAX_ITER_RST = '1;

	// |z|^2 threshold of 4.0 at 2*FRAC_BITS fraction bits
	localparam logic [P_W:0] ESC_LIMIT = (P_W + 1)'(1) << (2 * FRAC_BITS + 2);

	typedef struct packed {
		logic load;
		logic mul;
		logic step;
		logic cfg_we;
	} mbet_cmd_t;

	typedef struct packed {
		logic stop;
	} mbet_sts_t;

endpackage

### design/mbet_dp.sv
// Datapath: point registers, z iterate, squares, escape test and pass counter.
module mbet_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mbet_pkg::mbet_cmd_t                cmd,
	output mbet_pkg::mbet_sts_t                sts,
	input  logic signed [mbet_pkg::IN_W-1:0]   c_real,
	input  logic signed [mbet_pkg::IN_W-1:0]   c_imag,
	input  logic        [mbet_pkg::CNT_W-1:0]  cfg_data,
	output logic        [mbet_pkg::CNT_W-1:0]  iteration_count
);
	import mbet_pkg::*;

	logic [CNT_W-1:0]      max_q;
	logic [CNT_W-1:0]      count_q;
	logic signed [Z_W-1:0] cr_q, ci_q;
	logic signed [Z_W-1:0] zr_q, zi_q;
	logic signed [P_W-1:0] sr_s1, si_s1, xr_s1;

	logic signed [P_W:0]   diff;
	logic signed [P_W:0]   diff_sh;
	logic signed [P_W-1:0] cross_sh;
	logic        [P_W:0]   mag;
	logic        [CNT_W:0] count_inc;
	logic signed [Z_W-1:0] zr_n, zi_n;
	logic                  escaped;

	always_comb begin
		diff      = {sr_s1[P_W-1], sr_s1} - {si_s1[P_W-1], si_s1};
		diff_sh   = diff >>> FRAC_BITS;
		// doubling folds into a shift one place shorter
		cross_sh  = xr_s1 >>> (FRAC_BITS - 1);
		zr_n      = diff_sh[Z_W-1:0] + cr_q;
		zi_n      = cross_sh[Z_W-1:0] + ci_q;
		mag       = {1'b0, sr_s1} + {1'b0, si_s1};
		escaped   = mag >= ESC_LIMIT;
		count_inc = {1'b0, count_q} + (CNT_W + 1)'(1);
		sts.stop  = escaped || (count_inc >= {1'b0, max_q});
	end

	assign iteration_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_ITER_RST;
		end else if (cmd.cfg_we) begin
			max_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q    <= Z_W'(c_real);
			ci_q    <= Z_W'(c_imag);
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end else if (cmd.step) begin
			zr_q    <= zr_n;
			zi_q    <= zi_n;
			count_q <= count_inc[CNT_W-1:0];
		end
		if (cmd.mul) begin
			sr_s1 <= zr_q * zr_q;
			si_s1 <= zi_q * zi_q;
			xr_s1 <= zr_q * zi_q;
		end
	end

endmodule

### design/mbet_ctrl.sv
// Controller: sequences multiply and update cycles and raises the result strobe.
module mbet_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                cfg_valid,
	input  mbet_pkg::mbet_sts_t sts,
	output mbet_pkg::mbet_cmd_t cmd,
	output logic                busy,
	output logic                cfg_ready,
	output logic                done
);
	import mbet_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = !busy;
	assign done      = done_q;

	always_comb begin
		cmd.load   = start && (state_q == ST_IDLE);
		cmd.mul    = state_q == ST_MUL;
		cmd.step   = state_q == ST_ADD;
		cmd.cfg_we = cfg_valid && (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					// leave after the pass that escapes or reaches the limit
					if (sts.stop) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted point did not start");
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(state_q == ST_ADD && sts.stop))
		else $error("strobe without a stopping pass");
`endif

endmodule

### design/mandelbrot_escape_time_core.sv
// Top level of the Mandelbrot escape-time core: controller plus datapath.
//
//   channel   signals                          direction  transfer
//   point     start, busy, c_real, c_imag      in         start && !busy
//   result    done, iteration_count            out        done (one cycle)
//   config    cfg_valid, cfg_ready, cfg_data   in         cfg_valid && cfg_ready
//
// Each pass forms the three 32x32 products in ST_MUL, then does the update
// and escape test in ST_ADD. busy stays high until the strobe cycle, where a
// new point may already be taken. Reset sets the limit to 255. The receiver
// cannot stall; the word is dropped after its one cycle.
module mandelbrot_escape_time_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [mbet_pkg::IN_W-1:0]   c_real,
	input  logic signed [mbet_pkg::IN_W-1:0]   c_imag,
	output logic                               done,
	output logic        [mbet_pkg::CNT_W-1:0]  iteration_count,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic        [mbet_pkg::CNT_W-1:0]  cfg_data
);
	import mbet_pkg::*;

	mbet_cmd_t cmd;
	mbet_sts_t sts;

	mbet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done)
	);

	mbet_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.c_real          (c_real),
		.c_imag          (c_imag),
		.cfg_data        (cfg_data),
		.iteration_count (iteration_count)
	);

endmodule

### tb/tb_mandelbrot_escape_time_core.sv
// Self-checking testbench for the Mandelbrot escape-time core: random and corner points vs. a fixed-point predictor.
module tb_mandelbrot_escape_time_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mbet_pkg::*;

	localparam int  CYCLE_LIMIT = 5_000_000;
	localparam int  TAIL_CYCLES = 2 * 255 + 16;
	localparam int  FIX_ONE     = 1 << FRAC_BITS;
	localparam logic signed [IN_W-1:0] C_MIN  = {1'b1, {(IN_W-1){1'b0}}};
	localparam logic signed [IN_W-1:0] C_MAX  = {1'b0, {(IN_W-1){1'b1}}};
	localparam logic signed [127:0]    ESC_SQ = 128'sd1 <<< (2 * FRAC_BITS + 2);

	typedef struct {
		logic signed [IN_W-1:0] re;
		logic signed [IN_W-1:0] im;
	} point_t;

	typedef struct {
		point_t           pt;
		logic [CNT_W-1:0] count;
	} escape_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [IN_W-1:0] c_real;
	logic signed [IN_W-1:0] c_imag;
	logic done;
	logic [CNT_W-1:0] iteration_count;
	logic cfg_valid;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	point_t           pending_points[$];
	escape_word_t     expected_counts[$];
	logic [CNT_W-1:0] iter_limit = MAX_ITER_RST;
	int               sender_idle_pct = 0;
	int               mismatch_count = 0;
	int               cycle_count = 0;

	mandelbrot_escape_time_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.c_real(c_real),
		.c_imag(c_imag),
		.done(done),
		.iteration_count(iteration_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Iterate z = z*z + c with exact squares and floor after each product shift.
	function automatic logic [CNT_W-1:0] predict_escape_count(point_t pt,
			logic [CNT_W-1:0] limit);
		logic signed [63:0]  zr, zi, cr, ci;
		logic signed [127:0] sq_re, sq_im, twice_cross, re_part, im_part;
		logic [CNT_W-1:0]    passes, stop_at;
		logic                escaped;
		cr = pt.re;
		ci = pt.im;
		zr = '0;
		zi = '0;
		passes = '0;
		stop_at = (limit == '0) ? CNT_W'(1) : limit;
		do begin
			sq_re = zr * zr;
			sq_im = zi * zi;
			twice_cross = zr * zi * 2;
			re_part = (sq_re - sq_im) >>> FRAC_BITS;
			im_part = twice_cross >>> FRAC_BITS;
			escaped = (sq_re + sq_im) >= ESC_SQ;
			zr = re_part[63:0] + cr;
			zi = im_part[63:0] + ci;
			passes++;
		end while (passes < stop_at && !escaped);
		return passes;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Hold start while busy; advance to the next point once the word is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				escape_word_t w;
				w.pt = pending_points.pop_front();
				w.count = predict_escape_count(w.pt, iter_limit);
				expected_counts.push_back(w);
			end
			if (!(start && busy)) begin
				if (pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					start  <= 1'b1;
					c_real <= pending_points[0].re;
					c_imag <= pending_points[0].im;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				report_mismatch($sformatf("unexpected result, count %0d", iteration_count));
			end else begin
				escape_word_t w;
				w = expected_counts.pop_front();
				if (iteration_count !== w.count)
					report_mismatch($sformatf("c=(%0d,%0d): count %0d, expected %0d",
						w.pt.re, w.pt.im, iteration_count, w.count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_point(int re, int im);
		point_t pt;
		pt.re = IN_W'(re);
		pt.im = IN_W'(im);
		pending_points.push_back(pt);
	endtask

	// Mostly points around the set, where the loop runs long; the rest full range.
	task automatic queue_random(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 45)
				queue_point(int'($urandom), int'($urandom));
			else
				queue_point(int'($urandom_range(0, 671088640)) - 2 * FIX_ONE,
					int'($urandom_range(0, 644245094)) - 322122547);
		end
	endtask

	task automatic write_limit(logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		iter_limit = value;
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || expected_counts.size() > 0 || start)
			@(posedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		c_real    = '0;
		c_imag    = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner points at the reset limit
		sender_idle_pct = 29;
		queue_point(0, 0);
		queue_point(C_MIN, C_MIN);
		queue_point(C_MAX, C_MAX);
		queue_point(C_MIN, C_MAX);
		queue_point(C_MAX, C_MIN);
		queue_point(0, C_MIN);
		queue_point(0, C_MAX);
		queue_point(C_MIN, 0);
		queue_point(C_MAX, 0);
		queue_point(-2 * FIX_ONE, 0);
		queue_point(2 * FIX_ONE, 0);
		queue_point(FIX_ONE / 4, 0);
		queue_point(FIX_ONE / 4 + 1, 0);
		queue_point(-FIX_ONE, 0);
		queue_point(0, FIX_ONE);
		queue_point(-1, -1);
		queue_point(1, 1);
		queue_point(-1, 1);
		queue_point(-FIX_ONE / 2, FIX_ONE / 2);
		queue_point(-(3 * FIX_ONE) / 4, FIX_ONE / 10);
		queue_point(-FIX_ONE / 8, -FIX_ONE);
		drain();

		write_limit(8'd1);
		queue_random(250);
		drain();

		// Zero limit acts as one pass
		write_limit(8'd0);
		queue_random(150);
		drain();

		sender_idle_pct = 46;
		write_limit(8'd255);
		queue_random(600);
		drain();

		sender_idle_pct = 0;
		write_limit(CNT_W'($urandom_range(2, 254)));
		queue_random(500);
		drain();

		write_limit(8'd255);
		queue_random(500);
		drain();

		// Catch any stray strobe after the last word
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### filelist.f
design/mbet_pkg.sv
design/mbet_dp.sv
design/mbet_ctrl.sv
design/mandelbrot_escape_time_core.sv
tb/tb_mandelbrot_escape_time_core.sv
